>>> rtl/core/mesf_pkg.sv
// Shared types, widths and microcode ROM for the ellipse span fill engine.
// Used by mesf_dp, mesf_seq and midpoint_ellipse_span_fill_top; no dependencies.
`default_nettype none

package mesf_pkg;

  // Geometry widths
  localparam int RADIUS_BITS = 10;
  localparam int CEN_W       = 15;
  localparam int OUT_W       = 16;
  localparam int X_W         = RADIUS_BITS + 1;      // span half width
  localparam int Y_W         = RADIUS_BITS + 2;      // signed row offset, reaches -1
  localparam int SQ_W        = 2 * RADIUS_BITS;      // squared radius
  localparam int DEC_W       = 4 * RADIUS_BITS + 8;  // decision, x4 scaled
  localparam int A_W         = SQ_W + 1;             // signed multiplier operand A
  localparam int B_W         = 2 * X_W + 3;          // signed multiplier operand B
  localparam int P_W         = A_W + B_W;            // product

  // Item function codes
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  // Drawing phase
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_R1   = 2'd1;
  localparam logic [1:0] PH_R2   = 2'd2;

  // Microcode addresses
  localparam int UCODE_LEN = 22;
  localparam int UPC_W     = $clog2(UCODE_LEN);

  localparam logic [UPC_W-1:0] UA_ST_SQRX = UPC_W'(0);
  localparam logic [UPC_W-1:0] UA_ST_SQRY = UPC_W'(1);
  localparam logic [UPC_W-1:0] UA_ST_RXSQ = UPC_W'(2);
  localparam logic [UPC_W-1:0] UA_ST_RYSQ = UPC_W'(3);
  localparam logic [UPC_W-1:0] UA_ST_RXRY = UPC_W'(4);
  localparam logic [UPC_W-1:0] UA_ST_FIN  = UPC_W'(5);
  localparam logic [UPC_W-1:0] UA_R1_X    = UPC_W'(6);
  localparam logic [UPC_W-1:0] UA_R1_Y    = UPC_W'(7);
  localparam logic [UPC_W-1:0] UA_R1_CMP  = UPC_W'(8);
  localparam logic [UPC_W-1:0] UA_R1_EMIT = UPC_W'(9);
  localparam logic [UPC_W-1:0] UA_R1_DIAG = UPC_W'(10);
  localparam logic [UPC_W-1:0] UA_R1_HORZ = UPC_W'(11);
  localparam logic [UPC_W-1:0] UA_SW_TX   = UPC_W'(12);
  localparam logic [UPC_W-1:0] UA_SW_TXT  = UPC_W'(13);
  localparam logic [UPC_W-1:0] UA_SW_DY   = UPC_W'(14);
  localparam logic [UPC_W-1:0] UA_SW_DYT  = UPC_W'(15);
  localparam logic [UPC_W-1:0] UA_SW_RR   = UPC_W'(16);
  localparam logic [UPC_W-1:0] UA_SW_FIN  = UPC_W'(17);
  localparam logic [UPC_W-1:0] UA_R2_EMIT = UPC_W'(18);
  localparam logic [UPC_W-1:0] UA_R2_DIAG = UPC_W'(19);
  localparam logic [UPC_W-1:0] UA_R2_DFIN = UPC_W'(20);
  localparam logic [UPC_W-1:0] UA_R2_VERT = UPC_W'(21);

  typedef enum logic [2:0] {
    A_ZERO, A_RX, A_RY, A_RXSQ, A_RYSQ, A_TX, A_DY
  } a_sel_e;

  typedef enum logic [3:0] {
    B_ONE, B_RX, B_RY, B_RYSQ, B_X, B_Y, B_TX, B_DY, B_PROD,
    B_2X5, B_2Y, B_5M2Y, B_2X4
  } b_sel_e;

  typedef enum logic [2:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB, ACC_LDDEC
  } acc_op_e;

  typedef enum logic [1:0] {
    SQ_NONE, SQ_RX, SQ_RY
  } sq_sel_e;

  typedef enum logic [1:0] {
    PS_KEEP, PS_R1, PS_R2
  } ph_set_e;

  typedef enum logic [2:0] {
    C_NEXT, C_JUMP, C_ACC_NN, C_DEC_NEG, C_DEC_POS
  } cond_e;

  // One microcode control word
  typedef struct packed {
    a_sel_e           a_sel;
    b_sel_e           b_sel;
    logic             mul_en;
    acc_op_e          acc_op;
    logic             x4;
    logic             dec_we;
    sq_sel_e          sq_we;
    logic             x_inc;
    logic             y_dec;
    logic             xy_init;
    logic             emit;
    logic             last_chk;
    ph_set_e          ph_set;
    cond_e            cond;
    logic [UPC_W-1:0] target;
    logic             done;
  } cw_t;

  // Datapath flags seen by the sequencer
  typedef struct packed {
    logic acc_d_neg;
    logic dec_neg;
    logic dec_pos;
    logic y_zero;
  } dp_stat_t;

  // Sequencer status seen by the top level
  typedef struct packed {
    logic       busy;
    logic [1:0] phase;
    logic       emit;
    logic       last;
  } seq_stat_t;

  // Product register feeds the accumulator one step after the multiply.
  function automatic cw_t ucode(input logic [UPC_W-1:0] addr);
    cw_t w;
    w = '0;
    unique case (addr)
      // start: squares, then d = 4ry2 - 4rx2*ry + rx2
      UA_ST_SQRX: begin
        w.a_sel = A_RX;   w.b_sel = B_RX;  w.mul_en = 1'b1;
      end
      UA_ST_SQRY: begin
        w.a_sel = A_RY;   w.b_sel = B_RY;  w.mul_en = 1'b1;
        w.sq_we = SQ_RX;
      end
      UA_ST_RXSQ: begin
        w.a_sel = A_RXSQ; w.b_sel = B_ONE; w.mul_en = 1'b1;
        w.sq_we = SQ_RY;
      end
      UA_ST_RYSQ: begin
        w.acc_op = ACC_LOAD;
        w.a_sel = A_RYSQ; w.b_sel = B_ONE; w.mul_en = 1'b1;
      end
      UA_ST_RXRY: begin
        w.acc_op = ACC_ADD; w.x4 = 1'b1;
        w.a_sel = A_RXSQ; w.b_sel = B_RY;  w.mul_en = 1'b1;
      end
      UA_ST_FIN: begin
        w.acc_op = ACC_SUB; w.x4 = 1'b1; w.dec_we = 1'b1;
        w.xy_init = 1'b1; w.ph_set = PS_R1; w.done = 1'b1;
      end
      // region 1 span
      UA_R1_X: begin
        w.a_sel = A_RYSQ; w.b_sel = B_X;   w.mul_en = 1'b1;
      end
      UA_R1_Y: begin
        w.acc_op = ACC_LOAD;
        w.a_sel = A_RXSQ; w.b_sel = B_Y;   w.mul_en = 1'b1;
      end
      UA_R1_CMP: begin
        w.acc_op = ACC_SUB;
        w.a_sel = A_RYSQ; w.b_sel = B_2X5; w.mul_en = 1'b1;
        w.cond = C_ACC_NN; w.target = UA_SW_TX;
      end
      UA_R1_EMIT: begin
        w.emit = 1'b1; w.x_inc = 1'b1;
        w.acc_op = ACC_LDDEC; w.x4 = 1'b1;
        w.a_sel = A_RXSQ; w.b_sel = B_2Y;  w.mul_en = 1'b1;
        w.cond = C_DEC_NEG; w.target = UA_R1_HORZ;
      end
      UA_R1_DIAG: begin
        w.acc_op = ACC_SUB; w.x4 = 1'b1; w.dec_we = 1'b1;
        w.y_dec = 1'b1; w.done = 1'b1;
      end
      UA_R1_HORZ: begin
        w.dec_we = 1'b1; w.done = 1'b1;
      end
      // region switch: d = ry2*tx^2 + 4rx2*dy^2 - 4rx2*ry2
      UA_SW_TX: begin
        w.a_sel = A_TX;   w.b_sel = B_TX;  w.mul_en = 1'b1;
        w.ph_set = PS_R2;
      end
      UA_SW_TXT: begin
        w.a_sel = A_RYSQ; w.b_sel = B_PROD; w.mul_en = 1'b1;
      end
      UA_SW_DY: begin
        w.acc_op = ACC_LOAD;
        w.a_sel = A_DY;   w.b_sel = B_DY;  w.mul_en = 1'b1;
      end
      UA_SW_DYT: begin
        w.a_sel = A_RXSQ; w.b_sel = B_PROD; w.mul_en = 1'b1;
      end
      UA_SW_RR: begin
        w.acc_op = ACC_ADD; w.x4 = 1'b1;
        w.a_sel = A_RXSQ; w.b_sel = B_RYSQ; w.mul_en = 1'b1;
      end
      UA_SW_FIN: begin
        w.acc_op = ACC_SUB; w.x4 = 1'b1; w.dec_we = 1'b1;
        w.cond = C_JUMP; w.target = UA_R2_EMIT;
      end
      // region 2 span
      UA_R2_EMIT: begin
        w.emit = 1'b1; w.last_chk = 1'b1; w.y_dec = 1'b1;
        w.a_sel = A_RXSQ; w.b_sel = B_5M2Y; w.mul_en = 1'b1;
        w.cond = C_DEC_POS; w.target = UA_R2_VERT;
      end
      UA_R2_DIAG: begin
        w.x_inc = 1'b1;
        w.acc_op = ACC_LDDEC; w.x4 = 1'b1;
        w.a_sel = A_RYSQ; w.b_sel = B_2X4; w.mul_en = 1'b1;
      end
      UA_R2_DFIN: begin
        w.acc_op = ACC_ADD; w.x4 = 1'b1; w.dec_we = 1'b1; w.done = 1'b1;
      end
      UA_R2_VERT: begin
        w.acc_op = ACC_LDDEC; w.x4 = 1'b1; w.dec_we = 1'b1; w.done = 1'b1;
      end
      default: w.done = 1'b1;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/mesf_dp.sv
// Datapath of the ellipse span engine: one shared multiplier, accumulator,
// decision, step and squared-radius registers. Depends on mesf_pkg.
`default_nettype none

module mesf_dp (
  input  wire logic                                    clk_i,
  input  wire logic                                    ld_rad_i,
  input  wire logic        [mesf_pkg::RADIUS_BITS-1:0] radius_x_i,
  input  wire logic        [mesf_pkg::RADIUS_BITS-1:0] radius_y_i,
  input  wire mesf_pkg::cw_t                           cw_i,
  output mesf_pkg::dp_stat_t                           st_o,
  output logic             [mesf_pkg::X_W-1:0]         x_o,
  output logic signed      [mesf_pkg::Y_W-1:0]         y_o
);

  localparam int RB = mesf_pkg::RADIUS_BITS;
  localparam int XW = mesf_pkg::X_W;
  localparam int YW = mesf_pkg::Y_W;
  localparam int SW = mesf_pkg::SQ_W;
  localparam int DW = mesf_pkg::DEC_W;
  localparam int AW = mesf_pkg::A_W;
  localparam int BW = mesf_pkg::B_W;
  localparam int PW = mesf_pkg::P_W;

  logic        [RB-1:0] rx_q, ry_q;
  logic        [SW-1:0] rxsq_q, rysq_q;
  logic        [XW-1:0] x_q;
  logic signed [YW-1:0] y_q;
  logic signed [YW-1:0] dy;
  logic signed [PW-1:0] prod_q;
  logic signed [DW-1:0] acc_q, acc_d;
  logic signed [DW-1:0] dec_q;
  logic signed [DW-1:0] term_base, term;
  logic signed [AW-1:0] a_op;
  logic signed [BW-1:0] b_op;
  logic signed [BW-1:0] xe, ye;

  assign dy = y_q - YW'(1);
  assign xe = BW'(x_q);
  assign ye = BW'(y_q);

  always_comb begin
    unique case (cw_i.a_sel)
      mesf_pkg::A_RX:   a_op = AW'(rx_q);
      mesf_pkg::A_RY:   a_op = AW'(ry_q);
      mesf_pkg::A_RXSQ: a_op = AW'(rxsq_q);
      mesf_pkg::A_RYSQ: a_op = AW'(rysq_q);
      mesf_pkg::A_TX:   a_op = AW'({x_q, 1'b1});
      mesf_pkg::A_DY:   a_op = AW'(dy);
      default:          a_op = '0;
    endcase
  end

  always_comb begin
    unique case (cw_i.b_sel)
      mesf_pkg::B_ONE:  b_op = BW'(1);
      mesf_pkg::B_RX:   b_op = BW'(rx_q);
      mesf_pkg::B_RY:   b_op = BW'(ry_q);
      mesf_pkg::B_RYSQ: b_op = BW'(rysq_q);
      mesf_pkg::B_X:    b_op = xe;
      mesf_pkg::B_Y:    b_op = ye;
      mesf_pkg::B_TX:   b_op = BW'({x_q, 1'b1});
      mesf_pkg::B_DY:   b_op = BW'(dy);
      mesf_pkg::B_PROD: b_op = BW'(prod_q[2*XW+1:0]);
      mesf_pkg::B_2X5:  b_op = xe + xe + BW'(5);   // 2*(x+1)+3
      mesf_pkg::B_2Y:   b_op = ye + ye;            // 2*(y-1)+2
      mesf_pkg::B_5M2Y: b_op = BW'(5) - ye - ye;   // 3-2*(y-1)
      mesf_pkg::B_2X4:  b_op = xe + xe + BW'(4);   // 2*(x+1)+2
      default:          b_op = '0;
    endcase
  end

  assign term_base = DW'(prod_q);
  assign term      = cw_i.x4 ? (term_base <<< 2) : term_base;

  always_comb begin
    unique case (cw_i.acc_op)
      mesf_pkg::ACC_LOAD:  acc_d = term;
      mesf_pkg::ACC_ADD:   acc_d = acc_q + term;
      mesf_pkg::ACC_SUB:   acc_d = acc_q - term;
      mesf_pkg::ACC_LDDEC: acc_d = dec_q + term;
      default:             acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ld_rad_i) begin
      rx_q <= radius_x_i;
      ry_q <= radius_y_i;
    end
    if (cw_i.mul_en) prod_q <= a_op * b_op;
    acc_q <= acc_d;
    if (cw_i.dec_we) dec_q <= acc_d;
    unique case (cw_i.sq_we)
      mesf_pkg::SQ_RX: rxsq_q <= prod_q[SW-1:0];
      mesf_pkg::SQ_RY: rysq_q <= prod_q[SW-1:0];
      default: ;
    endcase
    if (cw_i.xy_init) begin
      x_q <= '0;
      y_q <= YW'(ry_q);
    end else begin
      if (cw_i.x_inc) x_q <= x_q + XW'(1);
      if (cw_i.y_dec) y_q <= y_q - YW'(1);
    end
  end

  assign st_o.acc_d_neg = acc_d[DW-1];
  assign st_o.dec_neg   = dec_q[DW-1];
  assign st_o.dec_pos   = !dec_q[DW-1] && (dec_q != '0);
  assign st_o.y_zero    = (y_q == '0);

  assign x_o = x_q;
  assign y_o = y_q;

endmodule

`default_nettype wire

>>> rtl/core/mesf_seq.sv
// Microcode sequencer: step counter, control ROM, branch logic and the
// drawing phase. Depends on mesf_pkg.
`default_nettype none

module mesf_seq (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_acc_i,
  input  wire logic                 func_i,
  input  wire logic                 rad_zero_i,
  input  wire logic                 out_blocked_i,
  input  wire mesf_pkg::dp_stat_t   dp_st_i,
  output mesf_pkg::cw_t             cw_o,
  output mesf_pkg::seq_stat_t       st_o
);

  localparam int UW = mesf_pkg::UPC_W;

  logic          busy_q, busy_d;
  logic [UW-1:0] upc_q, upc_d;
  logic [1:0]    phase_q, phase_d;
  mesf_pkg::cw_t rom_w;
  logic          step_go;
  logic          taken;

  assign rom_w   = mesf_pkg::ucode(upc_q);
  // an emit step waits while the output word is still held
  assign step_go = busy_q && !(rom_w.emit && out_blocked_i);
  assign cw_o    = step_go ? rom_w : '0;

  always_comb begin
    unique case (rom_w.cond)
      mesf_pkg::C_JUMP:    taken = 1'b1;
      mesf_pkg::C_ACC_NN:  taken = !dp_st_i.acc_d_neg;
      mesf_pkg::C_DEC_NEG: taken = dp_st_i.dec_neg;
      mesf_pkg::C_DEC_POS: taken = dp_st_i.dec_pos;
      default:             taken = 1'b0;
    endcase
  end

  always_comb begin
    busy_d  = busy_q;
    upc_d   = upc_q;
    phase_d = phase_q;
    if (in_acc_i) begin
      if (func_i == mesf_pkg::FUNC_START) begin
        if (rad_zero_i) begin
          phase_d = mesf_pkg::PH_IDLE;
        end else begin
          busy_d = 1'b1;
          upc_d  = mesf_pkg::UA_ST_SQRX;
        end
      end else begin
        unique case (phase_q)
          mesf_pkg::PH_R1: begin
            busy_d = 1'b1;
            upc_d  = mesf_pkg::UA_R1_X;
          end
          mesf_pkg::PH_R2: begin
            busy_d = 1'b1;
            upc_d  = mesf_pkg::UA_R2_EMIT;
          end
          default: ;
        endcase
      end
    end else if (step_go) begin
      upc_d = taken ? rom_w.target : upc_q + UW'(1);
      if (rom_w.done) busy_d = 1'b0;
      unique case (rom_w.ph_set)
        mesf_pkg::PS_R1: phase_d = mesf_pkg::PH_R1;
        mesf_pkg::PS_R2: phase_d = mesf_pkg::PH_R2;
        default: ;
      endcase
      if (rom_w.last_chk && dp_st_i.y_zero) phase_d = mesf_pkg::PH_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      upc_q   <= '0;
      phase_q <= mesf_pkg::PH_IDLE;
    end else begin
      busy_q  <= busy_d;
      upc_q   <= upc_d;
      phase_q <= phase_d;
    end
  end

  assign st_o.busy  = busy_q;
  assign st_o.phase = phase_q;
  assign st_o.emit  = step_go && rom_w.emit;
  assign st_o.last  = rom_w.last_chk && dp_st_i.y_zero;

endmodule

`default_nettype wire

>>> rtl/core/midpoint_ellipse_span_fill_top.sv
// Filled ellipse span generator, top level: handshakes, centre and output
// registers. Depends on mesf_pkg, mesf_seq and mesf_dp.
//
// Usage: an input word with func = start latches centre and radii (no output
// word); a zero radius leaves the engine idle. Each func = tick word then
// yields one output word: span columns, lower row, mirrored upper row,
// upper_valid (y nonzero) and last_span on the final span. A tick while idle
// is taken and yields nothing.
// Each start and each tick of an active ellipse is worked on by microcode steps
// that share one multiplier with a registered product. in_stall_o is high while
// a word is being worked on.
// Output: one register; the next input word is taken while a result waits.
// If out_stall_i keeps the register full, the sequencer holds at its emit
// step until the word is taken; nothing is lost.
// Reset (async, active low) returns to idle with no output word pending.
`default_nettype none

module midpoint_ellipse_span_fill_top (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  // input channel
  input  wire logic                                    in_valid_i,
  output logic                                         in_stall_o,
  input  wire logic                                    func_i,
  input  wire logic signed [mesf_pkg::CEN_W-1:0]       center_x_i,
  input  wire logic signed [mesf_pkg::CEN_W-1:0]       center_y_i,
  input  wire logic        [mesf_pkg::RADIUS_BITS-1:0] radius_x_i,
  input  wire logic        [mesf_pkg::RADIUS_BITS-1:0] radius_y_i,
  // output channel
  output logic                                         out_valid_o,
  input  wire logic                                    out_stall_i,
  output logic signed      [mesf_pkg::OUT_W-1:0]       span_left_o,
  output logic signed      [mesf_pkg::OUT_W-1:0]       span_right_o,
  output logic signed      [mesf_pkg::OUT_W-1:0]       row_lower_o,
  output logic signed      [mesf_pkg::OUT_W-1:0]       row_upper_o,
  output logic                                         upper_valid_o,
  output logic                                         last_span_o
);

  localparam int OW = mesf_pkg::OUT_W;
  localparam int CW = mesf_pkg::CEN_W;

  logic                          in_acc;
  logic                          start_acc;
  logic                          rad_zero;
  logic                          out_valid_q, out_valid_d;
  logic                          out_blocked;
  logic signed [CW-1:0]          cx_q, cy_q;
  logic signed [OW-1:0]          left_q, right_q, lower_q, upper_q;
  logic                          uvalid_q, last_q;
  logic [mesf_pkg::X_W-1:0]      x_w;
  logic signed [mesf_pkg::Y_W-1:0] y_w;
  mesf_pkg::cw_t                 cw;
  mesf_pkg::dp_stat_t            dp_st;
  mesf_pkg::seq_stat_t           seq_st;

  // one word in flight: stall while the sequencer runs
  assign in_stall_o = seq_st.busy;
  assign in_acc     = in_valid_i && !seq_st.busy;
  assign start_acc  = in_acc && (func_i == mesf_pkg::FUNC_START);
  assign rad_zero   = (radius_x_i == '0) || (radius_y_i == '0);

  assign out_blocked = out_valid_q && out_stall_i;

  mesf_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_acc_i      (in_acc),
    .func_i        (func_i),
    .rad_zero_i    (rad_zero),
    .out_blocked_i (out_blocked),
    .dp_st_i       (dp_st),
    .cw_o          (cw),
    .st_o          (seq_st)
  );

  mesf_dp u_dp (
    .clk_i      (clk_i),
    .ld_rad_i   (start_acc),
    .radius_x_i (radius_x_i),
    .radius_y_i (radius_y_i),
    .cw_i       (cw),
    .st_o       (dp_st),
    .x_o        (x_w),
    .y_o        (y_w)
  );

  // centre is latched on every start, zero radius included
  always_ff @(posedge clk_i) begin
    if (start_acc) begin
      cx_q <= center_x_i;
      cy_q <= center_y_i;
    end
  end

  // output word register
  assign out_valid_d = seq_st.emit || out_blocked;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_st.emit) begin
      left_q   <= OW'(cx_q) - OW'(x_w);
      right_q  <= OW'(cx_q) + OW'(x_w);
      lower_q  <= OW'(cy_q) + OW'(y_w);
      upper_q  <= OW'(cy_q) - OW'(y_w);
      uvalid_q <= !dp_st.y_zero;
      last_q   <= seq_st.last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign span_left_o   = left_q;
  assign span_right_o  = right_q;
  assign row_lower_o   = lower_q;
  assign row_upper_o   = upper_q;
  assign upper_valid_o = uvalid_q;
  assign last_span_o   = last_q;

`ifndef SYNTHESIS
  // final span sits on the centre row
  a_last_no_upper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_span_o) |-> !upper_valid_o)
    else $error("last span with mirrored row valid");

  // emitting the last span ends the ellipse
  a_last_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_st.emit && seq_st.last) |=> (seq_st.phase == mesf_pkg::PH_IDLE))
    else $error("phase not idle after last span");

  // spans only come from an active ellipse
  a_emit_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_st.emit |-> (seq_st.phase != mesf_pkg::PH_IDLE))
    else $error("span emitted while idle");

  // zero radius start or idle tick leaves the engine free
  a_no_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((start_acc && rad_zero) ||
     (in_acc && (func_i == mesf_pkg::FUNC_TICK) &&
      (seq_st.phase == mesf_pkg::PH_IDLE)))
    |=> (!seq_st.busy && (seq_st.phase == mesf_pkg::PH_IDLE)))
    else $error("engine started on an empty item");
`endif

endmodule

`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 1ps
// Testbench for midpoint_ellipse_span_fill_top: start and tick words in, span words out.
// Every span word is predicted by an untimed midpoint fill model and checked field by field.
// Depends on mesf_pkg and the RTL top level only.

module tb_top;

  localparam int RB           = mesf_pkg::RADIUS_BITS;
  localparam int CW           = mesf_pkg::CEN_W;
  localparam int OW           = mesf_pkg::OUT_W;
  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 5;
  localparam int RANDOM_WORDS = 500;
  localparam int BIG_TICKS    = 12;      // large ellipses are cut short
  localparam int TAIL_WORDS   = 80;      // last words go through with no idling
  localparam int DRAIN_CYCLES = 40;      // settling time after the last span is out
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RMAX         = (1 << RB) - 1;
  localparam int CMAX         = (1 << (CW - 1)) - 1;
  localparam int CMIN         = -(1 << (CW - 1));

  // One input word plus a flag that holds it back until all spans are out
  typedef struct {
    logic                 drain;
    logic                 func;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic        [RB-1:0] rx;
    logic        [RB-1:0] ry;
  } in_word_t;

  typedef struct {
    logic signed [OW-1:0] left;
    logic signed [OW-1:0] right;
    logic signed [OW-1:0] lower;
    logic signed [OW-1:0] upper;
    logic                 upper_valid;
    logic                 last;
  } span_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid;
  logic                 in_stall;
  in_word_t             cur_word;
  logic                 out_valid;
  logic                 out_stall;
  logic signed [OW-1:0] span_left;
  logic signed [OW-1:0] span_right;
  logic signed [OW-1:0] row_lower;
  logic signed [OW-1:0] row_upper;
  logic                 upper_valid;
  logic                 last_span;

  in_word_t pending_words[$];
  span_t    spans_due[$];
  bit       drain_next = 1'b0;
  bit       quiet;
  int       mismatches = 0;
  int       cycles = 0;

  // Driver and monitor burst state
  int       in_gap;
  int       in_calm;
  int       out_gap;
  int       out_calm;
  in_word_t next_word;
  span_t    want;

  // Ellipse model state
  logic [1:0]      el_phase = mesf_pkg::PH_IDLE;
  longint          el_x = 0;
  longint          el_y = 0;
  longint unsigned el_dec = 0;
  longint unsigned el_rx2 = 0;
  longint unsigned el_ry2 = 0;
  longint          el_cx = 0;
  longint          el_cy = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  midpoint_ellipse_span_fill_top u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .func_i       (cur_word.func),
    .center_x_i   (cur_word.cx),
    .center_y_i   (cur_word.cy),
    .radius_x_i   (cur_word.rx),
    .radius_y_i   (cur_word.ry),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .span_left_o  (span_left),
    .span_right_o (span_right),
    .row_lower_o  (row_lower),
    .row_upper_o  (row_upper),
    .upper_valid_o(upper_valid),
    .last_span_o  (last_span)
  );

  // ---------------------------------------------------------------------------
  // Fill model. All decision arithmetic is unsigned 64-bit and wraps, so the
  // sign of the decision is bit 63.
  // ---------------------------------------------------------------------------
  function automatic span_t span_at(bit last);
    span_t s;
    s.left        = OW'(el_cx - el_x);
    s.right       = OW'(el_cx + el_x);
    s.lower       = OW'(el_cy + el_y);
    s.upper       = OW'(el_cy - el_y);   // equals lower when y is zero
    s.upper_valid = (el_y != 0);
    s.last        = last;
    return s;
  endfunction

  task automatic ellipse_advance(input in_word_t w);
    span_t  s;
    bit     made;
    longint tx;
    longint dy;
    made = 1'b0;
    if (w.func == mesf_pkg::FUNC_START) begin
      // centre is latched even when a zero radius leaves the engine idle;
      // a start also abandons any ellipse in progress
      el_cx = 64'(w.cx);
      el_cy = 64'(w.cy);
      if (w.rx == 0 || w.ry == 0) begin
        el_phase = mesf_pkg::PH_IDLE;
      end else begin
        el_rx2   = 64'(w.rx) * 64'(w.rx);
        el_ry2   = 64'(w.ry) * 64'(w.ry);
        el_x     = 0;
        el_y     = 64'(w.ry);
        el_dec   = 4 * el_ry2 - 4 * el_rx2 * 64'(w.ry) + el_rx2;
        el_phase = mesf_pkg::PH_R1;
      end
    end else if (el_phase == mesf_pkg::PH_R1 &&
                 el_ry2 * 64'(el_x) < el_rx2 * 64'(el_y)) begin
      // region 1: step x, maybe y
      s    = span_at(1'b0);
      made = 1'b1;
      el_x++;
      if (el_dec[63]) begin
        el_dec += 4 * el_ry2 * (2 * el_x + 3);
      end else begin
        el_y--;
        el_dec += 4 * el_ry2 * (2 * el_x + 3) - 4 * el_rx2 * (2 * el_y + 2);
      end
    end else if (el_phase != mesf_pkg::PH_IDLE) begin
      if (el_phase == mesf_pkg::PH_R1) begin
        // region switch: new decision, then the first region 2 span right away
        tx       = 2 * el_x + 1;
        dy       = el_y - 1;
        el_dec   = el_ry2 * tx * tx + 4 * el_rx2 * (dy * dy) - 4 * el_rx2 * el_ry2;
        el_phase = mesf_pkg::PH_R2;
      end
      // region 2: the span at y == 0 is the last one
      s    = span_at(el_y < 1);
      made = 1'b1;
      el_y--;
      if (!el_dec[63] && el_dec != 0) begin
        el_dec += 4 * el_rx2 * (3 - 2 * el_y);
      end else begin
        el_x++;
        el_dec += 4 * el_ry2 * (2 * el_x + 2) + 4 * el_rx2 * (3 - 2 * el_y);
      end
      if (s.last) el_phase = mesf_pkg::PH_IDLE;
    end
    // a tick while idle falls through with no span
    if (made) spans_due.push_back(s);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_word(bit f, int cx, int cy, int rx, int ry);
    in_word_t w;
    w.drain    = drain_next;
    w.func     = f;
    w.cx       = CW'(cx);
    w.cy       = CW'(cy);
    w.rx       = RB'(rx);
    w.ry       = RB'(ry);
    drain_next = 1'b0;
    pending_words.push_back(w);
  endtask

  // Geometry fields of a tick are ignored, so they carry noise
  task automatic queue_ticks(int n);
    for (int i = 0; i < n; i++)
      queue_word(mesf_pkg::FUNC_TICK, $urandom_range(0, 32767), $urandom_range(0, 32767),
                 $urandom_range(0, RMAX), $urandom_range(0, RMAX));
  endtask

  task automatic queue_ellipse(int cx, int cy, int rx, int ry, int ticks);
    queue_word(mesf_pkg::FUNC_START, cx, cy, rx, ry);
    queue_ticks(ticks);
  endtask

  function automatic int rand_center();
    return int'($urandom_range(0, 32767)) + CMIN;
  endfunction

  // Mostly small ellipses keep the spans per start low
  function automatic int rand_radius();
    if ($urandom_range(0, 9) == 0) return $urandom_range(13, 60);
    return $urandom_range(1, 12);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents the pending words in order. A word marked drain waits
  // until every predicted span has come out. Prediction happens at accept.
  // ---------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid       <= 1'b0;
      cur_word.drain <= 1'b0;
      cur_word.func  <= mesf_pkg::FUNC_TICK;
      cur_word.cx    <= '0;
      cur_word.cy    <= '0;
      cur_word.rx    <= '0;
      cur_word.ry    <= '0;
      in_gap         <= 0;
      in_calm        <= 0;
      quiet          <= 1'b0;
    end else begin
      quiet <= (pending_words.size() < TAIL_WORDS);
      if (in_calm != 0) in_calm <= in_calm - 1;
      else if ($urandom_range(0, 63) == 0) in_calm <= $urandom_range(20, 150);

      if (in_valid && !in_stall) ellipse_advance(cur_word);

      if (!in_valid || !in_stall) begin
        if (in_gap != 0) begin
          in_valid <= 1'b0;
          in_gap   <= in_gap - 1;
        end else if (pending_words.size() != 0 &&
                     !(pending_words[0].drain && spans_due.size() != 0)) begin
          next_word = pending_words.pop_front();
          cur_word  <= next_word;
          in_valid  <= 1'b1;
          // idle burst after this word is taken
          if (!quiet && in_calm == 0 && $urandom_range(0, 3) == 0)
            in_gap <= $urandom_range(1, 7);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each taken span word against the oldest prediction and
  // stalls in random bursts.
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, logic signed [OW-1:0] exp_v,
                             logic signed [OW-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_gap   <= 0;
      out_calm  <= 0;
    end else begin
      if (out_valid === 1'b1 && !out_stall) begin
        if (spans_due.size() == 0) begin
          $error("span word with no prediction pending");
          mismatches++;
        end else begin
          want = spans_due.pop_front();
          check_field("span_left", want.left, span_left);
          check_field("span_right", want.right, span_right);
          check_field("row_lower", want.lower, row_lower);
          check_field("row_upper", want.upper, row_upper);
          check_field("upper_valid", OW'(want.upper_valid), OW'(upper_valid));
          check_field("last_span", OW'(want.last), OW'(last_span));
        end
      end

      if (out_calm != 0) out_calm <= out_calm - 1;
      else if ($urandom_range(0, 63) == 0) out_calm <= $urandom_range(20, 150);

      if (out_gap != 0) begin
        out_stall <= 1'b1;
        out_gap   <= out_gap - 1;
      end else begin
        out_stall <= 1'b0;
        if (!quiet && out_calm == 0 && $urandom_range(0, 7) == 0)
          out_gap <= $urandom_range(1, 7);
      end
    end
  end

  // Hard stop
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[midpoint_ellipse_span_fill_top] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Word list, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int n_random;
    int kind;
    int rx;
    int ry;
    int ticks;

    // directed: idle ticks, zero radii, tiny and lopsided ellipses,
    // centre extremes, an abandoned ellipse, ticks past the last span
    queue_ticks(2);
    queue_ellipse(0, 0, 0, 5, 1);
    queue_ellipse(0, 0, 5, 0, 1);
    queue_ellipse(0, 0, 1, 1, 4);
    queue_ellipse(100, -100, 3, 1, 6);
    queue_ellipse(-100, 100, 1, 3, 6);
    queue_ellipse(CMAX, CMIN, 2, 2, 6);
    queue_ellipse(CMIN, CMAX, 2, 2, 6);
    queue_ellipse(7, 7, 6, 4, 4);
    queue_ellipse(-7, -7, 4, 6, 12);

    // pause until every span is out, then the largest radii once each,
    // each cut short after its first spans
    drain_next = 1'b1;
    queue_ellipse(rand_center(), rand_center(), RMAX, RMAX, BIG_TICKS);
    queue_ellipse(rand_center(), rand_center(), RMAX, 1, BIG_TICKS);
    queue_ellipse(rand_center(), rand_center(), 1, RMAX, BIG_TICKS);

    // random part: mostly complete ellipses, some cut short, zero radius
    // starts and stray ticks
    n_random = 0;
    while (n_random < RANDOM_WORDS) begin
      kind = $urandom_range(0, 99);
      rx   = rand_radius();
      ry   = rand_radius();
      if (kind >= 90) begin
        ticks = $urandom_range(1, 3);
        queue_ticks(ticks);
        n_random += ticks;
      end else begin
        if (kind < 70) begin
          ticks = rx + ry + 2 + $urandom_range(0, 1);
        end else if (kind < 82) begin
          ticks = $urandom_range(0, rx + ry);
        end else begin
          if ($urandom_range(0, 1) == 1) rx = 0;
          else ry = 0;
          ticks = $urandom_range(0, 2);
        end
        if (kind % 20 == 3) drain_next = 1'b1;
        queue_ellipse(rand_center(), rand_center(), rx, ry, ticks);
        n_random += ticks + 1;
      end
    end

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    while (pending_words.size() != 0 || in_valid) @(posedge clk);
    while (spans_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && spans_due.size() == 0) begin
      $display("[midpoint_ellipse_span_fill_top] OK");
    end else begin
      $display("[midpoint_ellipse_span_fill_top] ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/mesf_pkg.sv
rtl/core/mesf_dp.sv
rtl/core/mesf_seq.sv
rtl/core/midpoint_ellipse_span_fill_top.sv
test/tb_top.sv
